// ===== rtl/gray_luma_histogram_defines.svh =====
// assertion macros used by the histogram back end
`ifndef GRAY_LUMA_HISTOGRAM_DEFINES_SVH
`define GRAY_LUMA_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define GLH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glh check failed");

// next-cycle implication, checked at every rising edge out of reset
`define GLH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glh check failed");

`endif

// ===== rtl/glh_pkg.sv =====
// package: types, constants and codes of the luma histogram
`timescale 1ns / 1ps
`default_nettype none
package glh_pkg;

  // sizes
  localparam int COUNT_BITS_DEF = 24;
  localparam int NUM_BINS       = 256;
  localparam int BIN_W          = 8;
  localparam int PIX_W          = 8;
  localparam int OUT_COUNT_W    = 24;
  localparam int BAR_W          = 9;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;

  // bt.601 weights in q0.8, summing to 256
  localparam logic [7:0] W_BLUE     = 8'd29;
  localparam logic [7:0] W_GREEN    = 8'd150;
  localparam logic [7:0] W_RED      = 8'd77;
  localparam int         LUMA_SHIFT = 8;
  localparam int         LUMA_SUM_W = 16;

  // bar height: count / 15 saturated at 280
  localparam int BAR_DIVISOR  = 15;
  localparam int BAR_LIMIT    = 280;
  localparam int BAR_SAT_MIN  = (BAR_LIMIT + 1) * BAR_DIVISOR;
  localparam int BAR_SMALL_W  = 13;
  localparam int BAR_RECIP_SH = 16;
  localparam int BAR_RECIP    = (1 << BAR_RECIP_SH) / BAR_DIVISOR + 1;
  localparam int BAR_PROD_W   = 2 * BAR_SMALL_W;
  localparam int BAR_CMP_W    = 32;

  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

  // item kinds
  typedef enum logic {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } glh_act_t;

  // input item
  typedef struct packed {
    glh_act_t           action;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    logic [BIN_W-1:0]   bin_index;
    logic               clear_on_read;
  } glh_in_t;

  // result item
  typedef struct packed {
    logic [PIX_W-1:0]       gray;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [BAR_W-1:0]       bar_height;
  } glh_out_t;

  // classified item handed from front to back
  typedef struct packed {
    glh_act_t         act;
    logic [BIN_W-1:0] idx;
    logic             clr;
  } glh_op_t;

endpackage
`default_nettype wire

// ===== rtl/gray_luma_histogram.sv =====
// top level: bgr to luma conversion with a 256-bin luma histogram
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------
//   input   | in        | push / full        | in_data  (glh_in_t)
//   result  | out       | pop / empty        | out_data (glh_out_t)
//
// one item per clock sustained while the result side keeps popping, set by the
// single-write bin store whose read-modify-write is closed by forwarding of the
// last write. an accepted item passes the front register, the front queue, the
// read stage and the result stage before it enters the result queue.
// reset clears the bin valid bits at once; no clearing pass, items are
// taken in the first cycle after reset.
// a stalled result side fills the result queue, then the front queue,
// then raises full.
`timescale 1ns / 1ps
`default_nettype none
module gray_luma_histogram
  import glh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire glh_in_t in_data,
  output logic         empty,
  input  wire logic    pop,
  output glh_out_t     out_data
);
  logic    fr_valid;
  glh_op_t fr_op;
  logic    mid_full;
  logic    mid_empty;
  logic    mid_pop;
  logic [$bits(glh_op_t)-1:0]     mid_dout;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_level;

  // front: luma and classification
  glh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .op_valid (fr_valid),
    .op_full  (mid_full),
    .op       (fr_op)
  );

  // decoupling queue between front and back
  glh_fifo #(
    .WIDTH ($bits(glh_op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .din   (fr_op),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .level (mid_level)
  );

  // back: bin store and results
  glh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (mid_empty || (mid_level == '0)),
    .op       (glh_op_t'(mid_dout)),
    .op_pop   (mid_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );
endmodule
`default_nettype wire

// ===== rtl/glh_fifo.sv =====
// small register fifo with a level output
`timescale 1ns / 1ps
`default_nettype none
module glh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  output logic                            full,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                dout,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      level
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // handshake
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store_r[rd_ptr_r];
  assign level   = cnt_r;

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/glh_front.sv =====
// front: accepts items, forms luma and classifies them into bin operations
`timescale 1ns / 1ps
`default_nettype none
module glh_front
  import glh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire glh_in_t in_data,
  output logic         op_valid,
  input  wire logic    op_full,
  output glh_op_t      op
);
  logic                  fr_v_r, fr_v_nxt;
  glh_op_t               fr_op_r, fr_op_nxt;
  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [PIX_W-1:0]      gray;
  logic                  take;

  // stage holds while the queue to the back is full
  assign full     = fr_v_r && op_full;
  assign take     = push && !full;
  assign op_valid = fr_v_r;
  assign op       = fr_op_r;

  // weighted sum, truncated to 8 bits
  always_comb begin
    luma_sum = LUMA_SUM_W'(LUMA_SUM_W'(W_BLUE)  * LUMA_SUM_W'(in_data.blue))
             + LUMA_SUM_W'(LUMA_SUM_W'(W_GREEN) * LUMA_SUM_W'(in_data.green))
             + LUMA_SUM_W'(LUMA_SUM_W'(W_RED)   * LUMA_SUM_W'(in_data.red));
    gray     = PIX_W'(luma_sum >> LUMA_SHIFT);
  end

  // classify the item
  always_comb begin
    fr_op_nxt     = fr_op_r;
    fr_op_nxt.act = in_data.action;
    unique case (in_data.action)
      ACT_ACCUM: begin
        fr_op_nxt.idx = gray;
        fr_op_nxt.clr = 1'b0;
      end
      ACT_READ: begin
        fr_op_nxt.idx = in_data.bin_index;
        fr_op_nxt.clr = in_data.clear_on_read;
      end
      default: begin
        fr_op_nxt.idx = in_data.bin_index;
        fr_op_nxt.clr = 1'b0;
      end
    endcase
    fr_v_nxt = take || (fr_v_r && op_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_op_r <= fr_op_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/glh_back.sv =====
// back: bin store read-modify-write, bar height and result queue
`timescale 1ns / 1ps
`default_nettype none
`include "gray_luma_histogram_defines.svh"
module glh_back
  import glh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     op_empty,
  input  wire glh_op_t  op,
  output logic          op_pop,
  output logic          empty,
  input  wire logic     pop,
  output glh_out_t      out_data
);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);
  localparam int SUM_W = OCW + 1;
  localparam int EXT_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

  // bin store with per-bin valid bits
  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [COUNT_BITS-1:0] mem_rd_r;
  logic                  vld_rd_r;

  // pipeline stages
  logic                  s1_v_r;
  glh_op_t               s1_op_r;
  logic                  s2_v_r;
  logic [PIX_W-1:0]      s2_gray_r;
  logic [COUNT_BITS-1:0] s2_count_r;

  // last write, for forwarding into the read stage
  logic                  wr_v_r;
  logic [BIN_W-1:0]      wr_addr_r;
  logic [COUNT_BITS-1:0] wr_data_r;

  logic                  fwd;
  logic [COUNT_BITS-1:0] old_cnt, inc_cnt, new_cnt, res_cnt;
  logic                  wen;
  logic [OCW-1:0]        olevel;
  logic                  ofull;
  logic [SUM_W-1:0]      inflight;
  logic [EXT_W-1:0]      cnt_ext;
  logic [BAR_CMP_W-1:0]  cnt_cmp;
  logic [BAR_PROD_W-1:0] bar_prod;
  logic [BAR_W-1:0]      bar;
  glh_out_t              res;
  logic [$bits(glh_out_t)-1:0] odout;

  // issue only when the result queue has room for everything in flight
  always_comb begin
    inflight = SUM_W'(olevel) + SUM_W'(s1_v_r) + SUM_W'(s2_v_r);
    op_pop   = !op_empty && (inflight < SUM_W'(OUT_DEPTH));
  end

  // read stage: merge forwarded value, valid bit and store data
  always_comb begin
    fwd     = wr_v_r && (wr_addr_r == s1_op_r.idx);
    old_cnt = fwd ? wr_data_r : (vld_rd_r ? mem_rd_r : '0);
    inc_cnt = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
    new_cnt = '0;
    res_cnt = old_cnt;
    wen     = 1'b0;
    unique case (s1_op_r.act)
      ACT_ACCUM: begin
        new_cnt = inc_cnt;
        res_cnt = inc_cnt;
        wen     = s1_v_r;
      end
      ACT_READ: begin
        wen = s1_v_r && s1_op_r.clr;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  // store read and write
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[s1_op_r.idx] <= new_cnt;
    end
    if (op_pop) begin
      mem_rd_r <= mem[op.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      wr_v_r <= 1'b0;
    end else begin
      if (wen) begin
        vld_r[s1_op_r.idx] <= 1'b1;
      end
      s1_v_r <= op_pop;
      s2_v_r <= s1_v_r;
      if (wen) begin
        wr_v_r <= 1'b1;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (op_pop) begin
      s1_op_r  <= op;
      vld_rd_r <= vld_r[op.idx];
    end
    if (wen) begin
      wr_addr_r <= s1_op_r.idx;
      wr_data_r <= new_cnt;
    end
    if (s1_v_r) begin
      s2_gray_r  <= (s1_op_r.act == ACT_ACCUM) ? s1_op_r.idx : '0;
      s2_count_r <= res_cnt;
    end
  end

  // result: saturated count and bar height by reciprocal multiply
  always_comb begin
    cnt_ext  = EXT_W'(s2_count_r);
    cnt_cmp  = BAR_CMP_W'(s2_count_r);
    bar_prod = BAR_PROD_W'(BAR_SMALL_W'(cnt_cmp[BAR_SMALL_W-1:0]))
             * BAR_PROD_W'(BAR_RECIP);
    if (cnt_cmp >= BAR_CMP_W'(BAR_SAT_MIN)) begin
      bar = BAR_W'(BAR_LIMIT);
    end else begin
      bar = BAR_W'(bar_prod >> BAR_RECIP_SH);
    end
    res.gray       = s2_gray_r;
    res.bin_count  = (cnt_ext > EXT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                       : cnt_ext[OUT_COUNT_W-1:0];
    res.bar_height = bar;
  end

  // result queue
  glh_fifo #(
    .WIDTH ($bits(glh_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s2_v_r),
    .din   (res),
    .full  (ofull),
    .pop   (pop),
    .dout  (odout),
    .empty (empty),
    .level (olevel)
  );

  assign out_data = glh_out_t'(odout);

  // checks
  `GLH_ASSERT_NOW(a_no_out_overflow, s2_v_r, !ofull)
  `GLH_ASSERT_NOW(a_accum_nonzero, s1_v_r && (s1_op_r.act == ACT_ACCUM), res_cnt != '0)
  `GLH_ASSERT_NOW(a_bar_limit, s2_v_r, bar <= BAR_W'(BAR_LIMIT))
  `GLH_ASSERT_NEXT(a_clear_writes_zero, wen && (s1_op_r.act == ACT_READ), wr_data_r == '0)
endmodule
`default_nettype wire

// ===== tb/glh_checker.sv =====
// checker: follows the luma histogram on both channels and compares every result item
`timescale 1ns / 1ps
module glh_checker
  import glh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     full,
  input  glh_in_t  in_data,
  input  logic     empty,
  input  logic     pop,
  input  glh_out_t out_data,
  output int       errors,
  output int       pending
);

  localparam int MAX_REPORTS = 30;

  // own copy of the bin store
  logic [COUNT_BITS-1:0] bin_store [NUM_BINS];
  glh_out_t              expected_results [$];

  // 8-bit luma, q0.8 weights, truncated
  function automatic logic [PIX_W-1:0] luma_of(glh_in_t it);
    logic [LUMA_SUM_W-1:0] acc;
    acc = LUMA_SUM_W'(W_BLUE) * it.blue + LUMA_SUM_W'(W_GREEN) * it.green
        + LUMA_SUM_W'(W_RED) * it.red;
    return acc[LUMA_SUM_W-1:LUMA_SHIFT];
  endfunction

  // count and bar height as shown on the result port
  function automatic glh_out_t shown_count(logic [PIX_W-1:0] g, logic [COUNT_BITS-1:0] cnt);
    glh_out_t         res;
    longint unsigned  c;
    longint unsigned  bar;
    c   = longint'(cnt);
    bar = c / BAR_DIVISOR;
    if (bar > BAR_LIMIT) bar = BAR_LIMIT;
    res.gray       = g;
    res.bin_count  = (c > longint'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : OUT_COUNT_W'(c);
    res.bar_height = BAR_W'(bar);
    return res;
  endfunction

  // applies one item to the bin store and returns the result it should give
  function automatic glh_out_t histogram_result(glh_in_t it);
    logic [PIX_W-1:0] g;
    glh_out_t         res;
    if (it.action == ACT_ACCUM) begin
      g = luma_of(it);
      // a full bin stays where it is
      if (bin_store[g] != '1) bin_store[g] = bin_store[g] + 1'b1;
      res = shown_count(g, bin_store[g]);
    end else begin
      res = shown_count('0, bin_store[it.bin_index]);
      if (it.clear_on_read) bin_store[it.bin_index] = '0;
    end
    return res;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    errors = errors + 1;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // compare the result item first, then predict the accepted input item
  always @(posedge clk) begin
    glh_out_t want;
    if (!rst_n) begin
      foreach (bin_store[i]) bin_store[i] = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display("%0t: result item with none expected, actual %p", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.gray !== want.gray) report("gray", want.gray, out_data.gray);
          if (out_data.bin_count !== want.bin_count)
            report("bin_count", want.bin_count, out_data.bin_count);
          if (out_data.bar_height !== want.bar_height)
            report("bar_height", want.bar_height, out_data.bar_height);
        end
      end
      if (push && !full) expected_results.push_back(histogram_result(in_data));
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: stimulus, flow control and verdict for the luma histogram
`timescale 1ns / 1ps
module tb;
  import glh_pkg::*;

  localparam int  RANDOM_ITEMS = 320;
  localparam int  FILL_ITEMS   = 150;
  localparam int  HOLD_CYCLES  = 150;
  localparam int  CYCLE_LIMIT  = 600000;

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  glh_in_t  in_data;
  logic     empty;
  logic     pop;
  glh_out_t out_data;
  int       errors;
  int       pending;

  logic     hold_request;
  logic     hold_done;
  int       burst_left;
  int       cycles;

  gray_luma_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  glh_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles = cycles + 1;
    end
    $display("Verification failed");
    $finish;
  end

  // pixel item, unused fields random
  function automatic glh_in_t pixel_item(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    glh_in_t it;
    it.action        = ACT_ACCUM;
    it.blue          = b;
    it.green         = g;
    it.red           = r;
    it.bin_index     = 8'($urandom);
    it.clear_on_read = 1'($urandom);
    return it;
  endfunction

  // readout item, pixel fields random
  function automatic glh_in_t readout_item(logic [7:0] idx, logic clr);
    glh_in_t it;
    it.action        = ACT_READ;
    it.blue          = 8'($urandom);
    it.green         = 8'($urandom);
    it.red           = 8'($urandom);
    it.bin_index     = idx;
    it.clear_on_read = clr;
    return it;
  endfunction

  // offer one item in bursts with random gaps; returns at the falling edge after accept
  task automatic offer_item(glh_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    end
    in_data = it;
    push    = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    burst_left = burst_left - 1;
  endtask

  // result side: changing stall patterns, one long hold-off on request
  initial begin
    int mode;
    int len;
    int period;
    int step;
    pop       = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        pop       = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode   = $urandom_range(3);
      len    = $urandom_range(100, 20);
      period = $urandom_range(5, 2);
      for (step = 0; step < len; step++) begin
        case (mode)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom);
          2:       pop = ($urandom_range(4) == 0);
          default: pop = (step % period == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0] hot [4];
    int         pick;
    int         v;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    hold_request = 1'b0;
    burst_left   = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: channel extremes, truncation, ignored fields, readout and clear
    offer_item(pixel_item(8'd0, 8'd0, 8'd0));
    offer_item(pixel_item(8'd255, 8'd255, 8'd255));
    offer_item(pixel_item(8'd255, 8'd0, 8'd0));
    offer_item(pixel_item(8'd0, 8'd255, 8'd0));
    offer_item(pixel_item(8'd0, 8'd0, 8'd255));
    offer_item(pixel_item(8'd8, 8'd0, 8'd0));
    offer_item(pixel_item(8'd9, 8'd0, 8'd0));
    offer_item(pixel_item(8'd1, 8'd1, 8'd1));
    offer_item(pixel_item(8'd254, 8'd254, 8'd254));
    offer_item(readout_item(8'd0, 1'b0));
    offer_item(readout_item(8'd0, 1'b1));
    offer_item(readout_item(8'd0, 1'b0));
    offer_item(readout_item(8'd255, 1'b1));
    offer_item(readout_item(8'd255, 1'b0));
    offer_item(readout_item(8'd28, 1'b0));
    offer_item(readout_item(8'd149, 1'b0));
    offer_item(readout_item(8'd76, 1'b1));
    offer_item(readout_item(8'd1, 1'b0));
    offer_item(readout_item(8'd200, 1'b1));
    offer_item(readout_item(8'd254, 1'b0));

    // fill bin zero with dark pixels, reading it back along the way
    for (int i = 0; i < FILL_ITEMS; i++) begin
      offer_item(pixel_item(8'($urandom_range(8)), 8'd0, 8'd0));
      if (i % 50 == 49) offer_item(readout_item(8'd0, 1'b0));
    end
    offer_item(readout_item(8'd0, 1'b1));
    offer_item(readout_item(8'd0, 1'b0));

    // random: grey pixels on a few hot bins and readouts of them, plus arbitrary pixels and readouts
    hot[0] = 8'd0;
    hot[1] = 8'd255;
    hot[2] = 8'($urandom);
    hot[3] = 8'($urandom);
    hold_request = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      v    = hot[$urandom_range(3)];
      if (pick < 35)
        offer_item(pixel_item(8'($urandom), 8'($urandom), 8'($urandom)));
      else if (pick < 60)
        offer_item(pixel_item(8'(v), 8'(v), 8'(v)));
      else if (pick < 80)
        offer_item(readout_item(8'(v), ($urandom_range(3) == 0)));
      else
        offer_item(readout_item(8'($urandom), 1'($urandom)));
    end
    push = 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
